// ----- rtl/sdrs_pkg.sv -----
// Shared types and constants for the SCAN disk request scheduler.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package sdrs_pkg;

   localparam int ID_W   = 8;
   localparam int CYL_W  = 8;
   localparam int TRK_W  = 5;
   localparam int REC_W  = 3;
   localparam int PEND_W = 5;

   localparam logic CMD_ADD      = 1'b0;
   localparam logic CMD_SCHEDULE = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [CYL_W-1:0] cyl;
      logic [TRK_W-1:0] trk;
      logic [REC_W-1:0] rec;
   } entry_type;

   typedef struct packed {
      logic              picked;
      logic              queue_empty;
      logic              add_rejected;
      entry_type         entry;
      logic              moving_up;
      logic [PEND_W-1:0] pending_count;
   } rsp_data_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic add_write;
      logic scan_read;
      logic scan_eval;
      logic decide;
      logic shift_read;
      logic shift_write;
      logic finish;
      logic rsp_load;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic scan_last;
      logic shift_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- rtl/sdrs_channels.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on sdrs_pkg for field widths.
interface sdrs_req_if import sdrs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             command;
   logic [ID_W-1:0]  request_id;
   logic [CYL_W-1:0] req_cylinder;
   logic [TRK_W-1:0] req_track;
   logic [REC_W-1:0] req_record;

   modport source (output valid, command, request_id, req_cylinder, req_track, req_record,
                   input ready);
   modport sink (input valid, command, request_id, req_cylinder, req_track, req_record,
                 output ready);
endinterface

interface sdrs_rsp_if import sdrs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              picked;
   logic              queue_empty;
   logic              add_rejected;
   logic [ID_W-1:0]   out_id;
   logic [CYL_W-1:0]  out_cylinder;
   logic [TRK_W-1:0]  out_track;
   logic [REC_W-1:0]  out_record;
   logic              moving_up;
   logic [PEND_W-1:0] pending_count;

   modport source (output valid, picked, queue_empty, add_rejected, out_id, out_cylinder,
                   out_track, out_record, moving_up, pending_count,
                   input ready);
   modport sink (input valid, picked, queue_empty, add_rejected, out_id, out_cylinder,
                 out_track, out_record, moving_up, pending_count,
                 output ready);
endinterface

// ----- rtl/sdrs_ctrl.sv -----
// Sequencing state machine of the scheduler: add, scan, decide, compact, respond.
// Depends on sdrs_pkg; drives the datapath through ctrl_cmd_type.
module sdrs_ctrl import sdrs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_ADD      = 9'b000000010,
      ST_SCAN_RD  = 9'b000000100,
      ST_SCAN_EV  = 9'b000001000,
      ST_DECIDE   = 9'b000010000,
      ST_SHIFT_RD = 9'b000100000,
      ST_SHIFT_WR = 9'b001000000,
      ST_FINISH   = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (req_command == CMD_ADD) begin
                  state_in = ST_ADD;
               end else if (status.empty) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_ADD: begin
            cmd.add_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            cmd.scan_eval = 1'b1;
            state_in      = status.scan_last ? ST_DECIDE : ST_SCAN_RD;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_SHIFT_RD;
         end
         ST_SHIFT_RD: begin
            if (status.shift_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.shift_read = 1'b1;
               state_in       = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_write = 1'b1;
            state_in        = ST_SHIFT_RD;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/sdrs_datapath.sv -----
// Request table memory, head position, scan candidates and response register.
// Depends on sdrs_pkg; commanded by sdrs_ctrl.
module sdrs_datapath import sdrs_pkg::*; #(
   parameter int TABLE_DEPTH       = 16,
   parameter int CYLINDER_COUNT    = 256,
   parameter int RECORDS_PER_TRACK = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic          in_command,
   input  entry_type     in_entry,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_data_type  rsp_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CYL_W-1:0] CYL_MAX =
      (CYLINDER_COUNT - 1 > 255) ? {CYL_W{1'b1}} : CYL_W'(CYLINDER_COUNT - 1);
   localparam logic [REC_W-1:0] REC_MAX =
      (RECORDS_PER_TRACK - 1 > 7) ? {REC_W{1'b1}} : REC_W'(RECORDS_PER_TRACK - 1);

   entry_type mem [TABLE_DEPTH];
   entry_type rdata_ff;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [CYL_W-1:0] head_cyl_ff;
   logic [REC_W-1:0] head_rec_ff;
   logic             sweep_ff;

   entry_type item_ff;
   entry_type pick_ff;
   logic      picked_ff, empty_ff, rej_ff;

   // scan candidates: on the head's cylinder, above it, below it
   logic             on_found_ff, up_found_ff, dn_found_ff;
   logic [REC_W-1:0] on_dist_ff;
   logic [CYL_W-1:0] up_dist_ff, dn_dist_ff;
   logic [CNT_W-1:0] on_slot_ff, up_slot_ff, dn_slot_ff;
   entry_type        on_entry_ff, up_entry_ff, dn_entry_ff;

   logic             rsp_valid_ff;
   rsp_data_type     rsp_data_ff;

   entry_type        sat_entry;
   logic [CNT_W-1:0] idx_next;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   entry_type        mem_wdata;
   logic [REC_W-1:0] e_on_dist;
   logic [CYL_W-1:0] e_up_dist, e_dn_dist;
   logic             e_on, e_up, e_dn;
   logic             take_on, take_up, take_dn;

   assign idx_next = idx_ff + CNT_W'(1);

   always_comb begin
      sat_entry = in_entry;
      if ({24'd0, in_entry.cyl} > 32'(CYLINDER_COUNT - 1)) begin
         sat_entry.cyl = CYL_MAX;
      end
      if ({29'd0, in_entry.rec} > 32'(RECORDS_PER_TRACK - 1)) begin
         sat_entry.rec = REC_MAX;
      end
   end

   assign status.empty      = (count_ff == '0);
   assign status.scan_last  = (idx_next == count_ff);
   assign status.shift_done = (idx_next >= count_ff);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // memory ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff[IDX_W-1:0];
      mem_wdata = rdata_ff;
      if (cmd.add_write && (count_ff != FULL_COUNT)) begin
         mem_we    = 1'b1;
         mem_waddr = count_ff[IDX_W-1:0];
         mem_wdata = item_ff;
      end else if (cmd.shift_write) begin
         mem_we = 1'b1;
      end
      mem_raddr = cmd.shift_read ? idx_next[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan_read || cmd.shift_read) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // compare the entry just read against the three candidates
   always_comb begin
      e_on      = (rdata_ff.cyl == head_cyl_ff);
      e_up      = (rdata_ff.cyl > head_cyl_ff);
      e_dn      = (rdata_ff.cyl < head_cyl_ff);
      e_on_dist = (rdata_ff.rec > head_rec_ff) ? rdata_ff.rec - head_rec_ff
                                               : head_rec_ff - rdata_ff.rec;
      e_up_dist = rdata_ff.cyl - head_cyl_ff;
      e_dn_dist = head_cyl_ff - rdata_ff.cyl;
      take_on   = e_on && (!on_found_ff || (e_on_dist < on_dist_ff));
      take_up   = e_up && (!up_found_ff || (e_up_dist < up_dist_ff) ||
                  ((e_up_dist == up_dist_ff) && (rdata_ff.rec < up_entry_ff.rec)));
      take_dn   = e_dn && (!dn_found_ff || (e_dn_dist < dn_dist_ff) ||
                  ((e_dn_dist == dn_dist_ff) && (rdata_ff.rec < dn_entry_ff.rec)));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_cyl_ff  <= '0;
         head_rec_ff  <= '0;
         sweep_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         on_found_ff  <= 1'b0;
         up_found_ff  <= 1'b0;
         dn_found_ff  <= 1'b0;
         picked_ff    <= 1'b0;
         empty_ff     <= 1'b0;
         rej_ff       <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (cmd.load_item) begin
            idx_ff      <= '0;
            on_found_ff <= 1'b0;
            up_found_ff <= 1'b0;
            dn_found_ff <= 1'b0;
            picked_ff   <= 1'b0;
            rej_ff      <= 1'b0;
            empty_ff    <= (in_command == CMD_SCHEDULE) && (count_ff == '0);
         end
         if (cmd.add_write) begin
            if (count_ff == FULL_COUNT) begin
               rej_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (cmd.scan_eval) begin
            idx_ff <= idx_next;
            if (take_on) on_found_ff <= 1'b1;
            if (take_up) up_found_ff <= 1'b1;
            if (take_dn) dn_found_ff <= 1'b1;
         end
         if (cmd.decide) begin
            picked_ff <= 1'b1;
            if (on_found_ff) begin
               idx_ff      <= on_slot_ff;
               head_cyl_ff <= on_entry_ff.cyl;
               head_rec_ff <= on_entry_ff.rec;
            end else if (sweep_ff ? up_found_ff : !dn_found_ff) begin
               // continue upward, or reverse to upward when nothing lies below
               sweep_ff    <= 1'b1;
               idx_ff      <= up_slot_ff;
               head_cyl_ff <= up_entry_ff.cyl;
               head_rec_ff <= up_entry_ff.rec;
            end else begin
               sweep_ff    <= 1'b0;
               idx_ff      <= dn_slot_ff;
               head_cyl_ff <= dn_entry_ff.cyl;
               head_rec_ff <= dn_entry_ff.rec;
            end
         end
         if (cmd.shift_write) begin
            idx_ff <= idx_next;
         end
         if (cmd.finish) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= sat_entry;
      end
      if (cmd.scan_eval) begin
         if (take_on) begin
            on_dist_ff  <= e_on_dist;
            on_slot_ff  <= idx_ff;
            on_entry_ff <= rdata_ff;
         end
         if (take_up) begin
            up_dist_ff  <= e_up_dist;
            up_slot_ff  <= idx_ff;
            up_entry_ff <= rdata_ff;
         end
         if (take_dn) begin
            dn_dist_ff  <= e_dn_dist;
            dn_slot_ff  <= idx_ff;
            dn_entry_ff <= rdata_ff;
         end
      end
      if (cmd.decide) begin
         if (on_found_ff) begin
            pick_ff <= on_entry_ff;
         end else if (sweep_ff ? up_found_ff : !dn_found_ff) begin
            pick_ff <= up_entry_ff;
         end else begin
            pick_ff <= dn_entry_ff;
         end
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.picked        <= picked_ff;
         rsp_data_ff.queue_empty   <= empty_ff;
         rsp_data_ff.add_rejected  <= rej_ff;
         rsp_data_ff.entry         <= picked_ff ? pick_ff : '0;
         rsp_data_ff.moving_up     <= sweep_ff;
         rsp_data_ff.pending_count <= PEND_W'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/scan_disk_request_scheduler_unit.sv -----
// Top level of the SCAN (elevator) disk request scheduler.
// Depends on sdrs_pkg, sdrs_channels, sdrs_ctrl and sdrs_datapath.
//
//   channel   direction   handshake          carries
//   req_bus   in          valid/ready        command, request_id, req_cylinder, req_track,
//                                            req_record
//   rsp_bus   out         valid/ready        picked, queue_empty, add_rejected, out_*,
//                                            moving_up, pending_count
//
// One transaction at a time. A schedule over N pending entries scans every entry and then
// compacts the entries after the picked slot; the table memory has one registered read port,
// so the scan and the compaction each spend a read state and a second state per entry.
// Reset is synchronous; it clears the count, head, direction and handshake state. Table
// contents are not cleared; only entries below the count are read.
// The output register lets a finished response wait while the next request is accepted;
// a following response holds in the controller until the register frees.
module scan_disk_request_scheduler_unit import sdrs_pkg::*; #(
   parameter int TABLE_DEPTH       = 16,
   parameter int CYLINDER_COUNT    = 256,
   parameter int RECORDS_PER_TRACK = 8
) (
   input logic        clock,
   input logic        reset,
   sdrs_req_if.sink   req_bus,
   sdrs_rsp_if.source rsp_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   entry_type     in_entry;
   rsp_data_type  rsp_data;
   logic          rsp_valid;

   assign in_entry.id  = req_bus.request_id;
   assign in_entry.cyl = req_bus.req_cylinder;
   assign in_entry.trk = req_bus.req_track;
   assign in_entry.rec = req_bus.req_record;

   sdrs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   sdrs_datapath #(
      .TABLE_DEPTH       (TABLE_DEPTH),
      .CYLINDER_COUNT    (CYLINDER_COUNT),
      .RECORDS_PER_TRACK (RECORDS_PER_TRACK)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_command (req_bus.command),
      .in_entry   (in_entry),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   assign rsp_bus.valid         = rsp_valid;
   assign rsp_bus.picked        = rsp_data.picked;
   assign rsp_bus.queue_empty   = rsp_data.queue_empty;
   assign rsp_bus.add_rejected  = rsp_data.add_rejected;
   assign rsp_bus.out_id        = rsp_data.entry.id;
   assign rsp_bus.out_cylinder  = rsp_data.entry.cyl;
   assign rsp_bus.out_track     = rsp_data.entry.trk;
   assign rsp_bus.out_record    = rsp_data.entry.rec;
   assign rsp_bus.moving_up     = rsp_data.moving_up;
   assign rsp_bus.pending_count = rsp_data.pending_count;

   // at most one outcome flag per response
   a_outcome_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data.picked, rsp_data.queue_empty, rsp_data.add_rejected}))
      else $error("conflicting outcome flags");

   // a picked request always lies inside the saturated ranges
   a_pick_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.picked) |->
         (({24'd0, rsp_data.entry.cyl} <= 32'(CYLINDER_COUNT - 1)) &&
          ({29'd0, rsp_data.entry.rec} <= 32'(RECORDS_PER_TRACK - 1))))
      else $error("picked request out of range");

   // an accepted transaction takes the controller out of idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while busy");

   // a response load only happens into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || rsp_bus.ready))
      else $error("response overwritten");

endmodule

// ----- tb/tb_scan_disk_request_scheduler_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the SCAN disk request scheduler top level.
// Depends on sdrs_pkg, the sdrs_req_if / sdrs_rsp_if channels and the RTL under rtl/.
module tb_scan_disk_request_scheduler_unit import sdrs_pkg::*;;

   localparam int TABLE_DEPTH       = 16;
   localparam int CYLINDER_COUNT    = 256;
   localparam int RECORDS_PER_TRACK = 8;
   localparam int CYL_TOP           = CYLINDER_COUNT - 1;
   localparam int REC_TOP           = RECORDS_PER_TRACK - 1;
   localparam int RAND_ITEMS        = 825;
   localparam int QUIET_FROM        = 770;
   localparam int HOLD_AT           = 300;
   localparam int DRAIN_AT          = 550;
   localparam int HOLD_CYCLES       = 300;
   localparam int TAIL_CYCLES       = 100;
   localparam int TIMEOUT_NS        = 1_000_000;
   localparam int DIR_ROWS          = 25;

   typedef struct {
      logic              cmd;
      logic [ID_W-1:0]   id;
      logic [CYL_W-1:0]  cyl;
      logic [TRK_W-1:0]  trk;
      logic [REC_W-1:0]  rec;
   } disk_req_type;

   typedef struct {
      disk_req_type req;
      bit           known;
      rsp_data_type exp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdrs_req_if req_if ();
   sdrs_rsp_if rsp_if ();

   scan_disk_request_scheduler_unit #(
      .TABLE_DEPTH      (TABLE_DEPTH),
      .CYLINDER_COUNT   (CYLINDER_COUNT),
      .RECORDS_PER_TRACK(RECORDS_PER_TRACK)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if)
   );

   // Directed rows: after reset, extremes, fill to full and reject, tie-breaks, reversal.
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{'{CMD_SCHEDULE, 8'h00, 8'd0,   5'd0,  3'd0}, 1'b1, '{1'b0, 1'b1, 1'b0, '0, 1'b1, 5'd0}},
      '{'{CMD_ADD,      8'hFF, 8'd255, 5'd31, 3'd7}, 1'b1, '{1'b0, 1'b0, 1'b0, '0, 1'b1, 5'd1}},
      '{'{CMD_ADD,      8'h00, 8'd0,   5'd0,  3'd0}, 1'b1, '{1'b0, 1'b0, 1'b0, '0, 1'b1, 5'd2}},
      '{'{CMD_SCHEDULE, 8'h00, 8'd0,   5'd0,  3'd0}, 1'b1, '{1'b1, 1'b0, 1'b0, '0, 1'b1, 5'd1}},
      '{'{CMD_SCHEDULE, 8'h00, 8'd0,   5'd0,  3'd0}, 1'b1,
        '{1'b1, 1'b0, 1'b0, '{8'hFF, 8'd255, 5'd31, 3'd7}, 1'b1, 5'd0}},
      '{'{CMD_ADD,      8'h10, 8'd255, 5'd1,  3'd5}, 1'b0, '0},
      '{'{CMD_ADD,      8'h11, 8'd255, 5'd2,  3'd5}, 1'b0, '0},
      '{'{CMD_ADD,      8'h12, 8'd254, 5'd3,  3'd2}, 1'b0, '0},
      '{'{CMD_ADD,      8'h13, 8'd254, 5'd4,  3'd2}, 1'b0, '0},
      '{'{CMD_ADD,      8'h14, 8'd254, 5'd5,  3'd6}, 1'b0, '0},
      '{'{CMD_ADD,      8'h15, 8'd0,   5'd6,  3'd0}, 1'b0, '0},
      '{'{CMD_ADD,      8'h16, 8'd1,   5'd7,  3'd7}, 1'b0, '0},
      '{'{CMD_ADD,      8'h17, 8'd128, 5'd8,  3'd3}, 1'b0, '0},
      '{'{CMD_ADD,      8'h18, 8'd128, 5'd9,  3'd3}, 1'b0, '0},
      '{'{CMD_ADD,      8'h19, 8'd200, 5'd10, 3'd4}, 1'b0, '0},
      '{'{CMD_ADD,      8'h1A, 8'd63,  5'd11, 3'd1}, 1'b0, '0},
      '{'{CMD_ADD,      8'h1B, 8'd3,   5'd12, 3'd0}, 1'b0, '0},
      '{'{CMD_ADD,      8'h1C, 8'd100, 5'd13, 3'd6}, 1'b0, '0},
      '{'{CMD_ADD,      8'h1D, 8'd2,   5'd14, 3'd2}, 1'b0, '0},
      '{'{CMD_ADD,      8'h1E, 8'd250, 5'd15, 3'd7}, 1'b0, '0},
      '{'{CMD_ADD,      8'h1F, 8'd50,  5'd16, 3'd5}, 1'b0, '0},
      '{'{CMD_ADD,      8'hAA, 8'h55,  5'h15, 3'd2}, 1'b1, '{1'b0, 1'b0, 1'b1, '0, 1'b1, 5'd16}},
      '{'{CMD_SCHEDULE, 8'h00, 8'd0,   5'd0,  3'd0}, 1'b0, '0},
      '{'{CMD_SCHEDULE, 8'h00, 8'd0,   5'd0,  3'd0}, 1'b0, '0},
      '{'{CMD_SCHEDULE, 8'h00, 8'd0,   5'd0,  3'd0}, 1'b0, '0}
   };

   logic [CYL_W-1:0] hot_cyl [5] = '{8'd0, 8'd63, 8'd128, 8'd200, 8'd255};

   // Scheduler mirror state
   entry_type        pend_tab [TABLE_DEPTH];
   int               pend_n   = 0;
   logic [CYL_W-1:0] head_cyl = '0;
   logic [REC_W-1:0] head_rec = '0;
   logic             sweep_up = 1'b1;

   rsp_data_type rsp_due_q [$];
   int           err_count = 0;
   int           n_add = 0, n_reject = 0, n_pick = 0, n_empty = 0, n_reversal = 0;
   bit           hold_go = 1'b0;
   logic         hold_long = 1'b0;
   logic         quiet = 1'b0;

   function automatic bit nearest_way(input logic up, output int slot);
      bit          found;
      int unsigned best_d, d;
      logic [REC_W-1:0] best_r;
      found  = 1'b0;
      best_d = 0;
      best_r = '0;
      slot   = 0;
      for (int i = 0; i < pend_n; i++) begin
         if (up ? (pend_tab[i].cyl <= head_cyl) : (pend_tab[i].cyl >= head_cyl))
            continue;
         d = up ? pend_tab[i].cyl - head_cyl : head_cyl - pend_tab[i].cyl;
         if (!found || d < best_d || (d == best_d && pend_tab[i].rec < best_r)) begin
            found  = 1'b1;
            best_d = d;
            best_r = pend_tab[i].rec;
            slot   = i;
         end
      end
      return found;
   endfunction

   // Advance the mirror by one transaction and return the response it must produce.
   function automatic rsp_data_type scan_next(input disk_req_type rq);
      rsp_data_type r;
      entry_type    e;
      int           slot;
      bit           on_cyl;
      int unsigned  d, best_d;
      r      = '0;
      slot   = 0;
      on_cyl = 1'b0;
      best_d = 0;
      if (rq.cmd == CMD_ADD) begin
         if (pend_n >= TABLE_DEPTH) begin
            r.add_rejected = 1'b1;
            n_reject++;
         end else begin
            e.id  = rq.id;
            e.cyl = (rq.cyl > CYL_TOP) ? CYL_W'(CYL_TOP) : rq.cyl;
            e.trk = rq.trk;
            e.rec = (rq.rec > REC_TOP) ? REC_W'(REC_TOP) : rq.rec;
            pend_tab[pend_n] = e;
            pend_n++;
            n_add++;
         end
      end else if (pend_n == 0) begin
         r.queue_empty = 1'b1;
         n_empty++;
      end else begin
         for (int i = 0; i < pend_n; i++) begin
            if (pend_tab[i].cyl == head_cyl) begin
               d = (pend_tab[i].rec > head_rec) ? pend_tab[i].rec - head_rec
                                                : head_rec - pend_tab[i].rec;
               if (!on_cyl || d < best_d) begin
                  on_cyl = 1'b1;
                  best_d = d;
                  slot   = i;
               end
            end
         end
         if (!on_cyl) begin
            if (!nearest_way(sweep_up, slot)) begin
               // nothing ahead: reverse the sweep
               sweep_up = ~sweep_up;
               n_reversal++;
               void'(nearest_way(sweep_up, slot));
            end
         end
         r.picked = 1'b1;
         r.entry  = pend_tab[slot];
         head_cyl = pend_tab[slot].cyl;
         head_rec = pend_tab[slot].rec;
         for (int i = slot; i + 1 < pend_n; i++)
            pend_tab[i] = pend_tab[i + 1];
         pend_n--;
         n_pick++;
      end
      r.moving_up     = sweep_up;
      r.pending_count = PEND_W'(pend_n);
      return r;
   endfunction

   task automatic cmp_field(input string name, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         err_count++;
      end
   endtask

   // Offer one transaction, hold it until accepted, then record what it must return.
   task automatic send_req(input disk_req_type rq, input bit known, input rsp_data_type exp);
      rsp_data_type pred;
      req_if.valid        <= 1'b1;
      req_if.command      <= rq.cmd;
      req_if.request_id   <= rq.id;
      req_if.req_cylinder <= rq.cyl;
      req_if.req_track    <= rq.trk;
      req_if.req_record   <= rq.rec;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pred = scan_next(rq);
      rsp_due_q.push_back(known ? exp : pred);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Long receiver hold-off so the block backs up onto its input
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_long <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_long <= 1'b0;
   end

   // Response side: check accepted transactions, stall in random bursts
   initial begin
      int           stall_left;
      rsp_data_type exp;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (rsp_due_q.size() == 0) begin
               $error("response with nothing outstanding");
               err_count++;
            end else begin
               exp = rsp_due_q.pop_front();
               cmp_field("picked",        exp.picked,        rsp_if.picked);
               cmp_field("queue_empty",   exp.queue_empty,   rsp_if.queue_empty);
               cmp_field("add_rejected",  exp.add_rejected,  rsp_if.add_rejected);
               cmp_field("out_id",        exp.entry.id,      rsp_if.out_id);
               cmp_field("out_cylinder",  exp.entry.cyl,     rsp_if.out_cylinder);
               cmp_field("out_track",     exp.entry.trk,     rsp_if.out_track);
               cmp_field("out_record",    exp.entry.rec,     rsp_if.out_record);
               cmp_field("moving_up",     exp.moving_up,     rsp_if.moving_up);
               cmp_field("pending_count", exp.pending_count, rsp_if.pending_count);
            end
         end
         if (hold_long) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 14);
         end
      end
   end

   // Request side: directed table, then random traffic
   initial begin
      disk_req_type rq;
      int           add_bias;
      req_if.valid        <= 1'b0;
      req_if.command      <= CMD_ADD;
      req_if.request_id   <= '0;
      req_if.req_cylinder <= '0;
      req_if.req_track    <= '0;
      req_if.req_record   <= '0;
      add_bias = 50;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[k])
         send_req(dir_tab[k].req, dir_tab[k].known, dir_tab[k].exp);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         // swing between filling and draining phases
         if (n % 60 == 0)
            add_bias = $urandom_range(20, 80);
         if (n == QUIET_FROM)
            quiet <= 1'b1;
         if (n == HOLD_AT)
            hold_go = 1'b1;
         if (n == DRAIN_AT) begin
            req_if.valid <= 1'b0;
            while (rsp_due_q.size() != 0) @(posedge clock);
         end
         rq.cmd = ($urandom_range(0, 99) < add_bias) ? CMD_ADD : CMD_SCHEDULE;
         rq.id  = ID_W'($urandom_range(0, 255));
         case ($urandom_range(0, 3))
            0: rq.cyl = CYL_W'($urandom_range(0, 255));
            1: rq.cyl = head_cyl;
            2: rq.cyl = hot_cyl[$urandom_range(0, 4)];
            default: rq.cyl = CYL_W'(head_cyl + $urandom_range(0, 6) - 3);
         endcase
         rq.trk = TRK_W'($urandom_range(0, 31));
         rq.rec = REC_W'($urandom_range(0, 7));
         send_req(rq, 1'b0, '0);
      end

      req_if.valid <= 1'b0;
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d adds, %0d rejected adds, %0d picks, %0d empty schedules,",
               n_add, n_reject, n_pick, n_empty);
      $display("with %0d sweep reversals, a long response hold-off and a full drain.",
               n_reversal);
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
